// ===== design/fbsc_pkg.sv =====
`timescale 1ns / 1ps
package fbsc_pkg;

	localparam int NUM_PLANES = 6;

	localparam logic [1:0] MODE_LOAD   = 2'd0;
	localparam logic [1:0] MODE_BOX    = 2'd1;
	localparam logic [1:0] MODE_SPHERE = 2'd2;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_NOPLN  = 2'd1;
	localparam logic [1:0] STAT_DEGEN  = 2'd2;

	localparam logic signed [31:0] FMT_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] FMT_MIN = 32'sh80000000;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_RAW  = 7'b0000010,
		ST_SQRT = 7'b0000100,
		ST_NORM = 7'b0001000,
		ST_DIV  = 7'b0010000,
		ST_TEST = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	// handshake of an iterative unit toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	// matrix row combined with row 3 for each plane
	function automatic logic [1:0] plane_row(input logic [2:0] p);
		logic [1:0] r;
		case (p)
			3'd0, 3'd1: r = 2'd2;
			3'd2, 3'd3: r = 2'd0;
			3'd4, 3'd5: r = 2'd1;
			default:    r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic logic plane_plus(input logic [2:0] p);
		logic s;
		case (p)
			3'd0, 3'd2, 3'd5: s = 1'b1;
			default:          s = 1'b0;
		endcase
		return s;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
		logic signed [31:0] r;
		if (v > 33'sd2147483647)
			r = FMT_MAX;
		else if (v < -33'sd2147483648)
			r = FMT_MIN;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

// ===== design/fbsc_mul.sv =====
`timescale 1ns / 1ps
module fbsc_mul (
	input  logic               clk,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic signed [63:0] prod
);
	logic signed [63:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;
endmodule

// ===== design/fbsc_sqrt.sv =====
`timescale 1ns / 1ps
module fbsc_sqrt (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [63:0]          x,
	output fbsc_pkg::unit_stat_t stat,
	output logic [31:0]          root
);
	logic [63:0] x_q, res_q, bit_q, trial;
	logic [4:0]  cnt_q;
	logic        busy_q, done_q;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			x_q    <= '0;
			res_q  <= '0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				x_q    <= x;
				res_q  <= '0;
				bit_q  <= 64'h4000_0000_0000_0000;
			end else if (busy_q) begin
				// one result bit per cycle
				if (x_q >= trial) begin
					x_q   <= x_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign root      = res_q[31:0];
endmodule

// ===== design/fbsc_div.sv =====
`timescale 1ns / 1ps
module fbsc_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [63:0]          num,
	input  logic [31:0]          den,
	output fbsc_pkg::unit_stat_t stat,
	output logic [63:0]          quot
);
	logic [63:0] num_q, quot_q;
	logic [31:0] den_q;
	logic [32:0] rem_q, rem_sh;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q, ge;

	assign rem_sh = {rem_q[31:0], num_q[63]};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			num_q  <= '0;
			quot_q <= '0;
			den_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				num_q  <= num;
				den_q  <= den;
				rem_q  <= '0;
				quot_q <= '0;
			end else if (busy_q) begin
				// restoring step, one quotient bit per cycle
				rem_q  <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
				quot_q <= {quot_q[62:0], ge};
				num_q  <= {num_q[62:0], 1'b0};
				cnt_q  <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = quot_q;
endmodule

// ===== design/frustum_box_sphere_cull_top.sv =====
`timescale 1ns / 1ps
// channel | signals                                          | beat
// in      | in_valid, in_ready, mode .. extra_value          | one load, box or sphere item
// out     | out_valid, out_ready, visible, status            | one result per input beat
//
// box or sphere test: each plane steps through its components on the shared multiplier
//   between accept and result; a rejecting plane ends the walk early
// non-test items, sentinel boxes and tests without valid planes go from accept to result
// the load that completes all four columns builds the planes: per plane a raw pass, a
//   square root and a divide per component, skipped for a zero length
// async reset clears the column marks and plane flags; matrix and plane stores are
//   undefined until written; in_ready is low while an item is at work
// a result waits in the output register without blocking the next input beat
module frustum_box_sphere_cull_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         mode,
	input  logic [1:0]         column_index,
	input  logic signed [31:0] first_x,
	input  logic signed [31:0] first_y,
	input  logic signed [31:0] first_z,
	input  logic signed [31:0] second_x,
	input  logic signed [31:0] second_y,
	input  logic signed [31:0] second_z,
	input  logic signed [31:0] offset_x,
	input  logic signed [31:0] offset_y,
	input  logic signed [31:0] offset_z,
	input  logic signed [31:0] extra_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               visible,
	output logic [1:0]         status
);
	fbsc_pkg::state_t state_q;

	// storage, no reset
	logic signed [31:0] row3_q [4];
	logic signed [31:0] rowx_q [12];
	logic signed [31:0] pl_q   [24];
	logic signed [31:0] lo_q   [3];
	logic signed [31:0] hi_q   [3];
	logic signed [31:0] raw_q  [4];
	logic signed [32:0] ext_q;

	// control
	logic [2:0]         p_q;
	logic [1:0]         k_q;
	logic signed [65:0] acc_q;
	logic [63:0]        sum_q;
	logic [31:0]        len_q;
	logic [3:0]         cols_q;
	logic               ready_q, degen_q, vis_q;
	logic               out_valid_q, visible_q;
	logic [1:0]         status_q;

	logic               accept, sentinel, not_ready;
	logic [3:0]         cols_nx;
	logic signed [31:0] r3, ri, raw_c, comp, corner, mul_a, mul_b, nrm;
	logic signed [63:0] prod;
	logic signed [65:0] total, rhs;
	logic [31:0]        mag;
	logic [63:0]        quot;
	logic               sqrt_start, div_start, norm_adv, reject;
	logic [31:0]        root;
	logic [1:0]         fin_status;
	fbsc_pkg::unit_stat_t sqrt_stat, div_stat;

	assign in_ready = (state_q == fbsc_pkg::ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign cols_nx  = cols_q | (4'd1 << column_index);
	assign not_ready = !ready_q || degen_q;
	assign sentinel = first_x == fbsc_pkg::FMT_MAX && first_y == fbsc_pkg::FMT_MAX &&
		first_z == fbsc_pkg::FMT_MAX && second_x == fbsc_pkg::FMT_MIN &&
		second_y == fbsc_pkg::FMT_MIN && second_z == fbsc_pkg::FMT_MIN;

	// raw plane component: row 3 plus or minus the selected row of column k
	assign r3    = row3_q[k_q];
	assign ri    = rowx_q[{fbsc_pkg::plane_row(p_q), k_q}];
	assign raw_c = fbsc_pkg::plane_plus(p_q) ?
		fbsc_pkg::sat32(33'(r3) + 33'(ri)) : fbsc_pkg::sat32(33'(r3) - 33'(ri));

	// plane component and positive corner for the test walk
	assign comp = pl_q[{p_q, k_q}];
	always_comb begin
		case (k_q)
			2'd0:    corner = (comp > 0) ? hi_q[0] : lo_q[0];
			2'd1:    corner = (comp > 0) ? hi_q[1] : lo_q[1];
			2'd2:    corner = (comp > 0) ? hi_q[2] : lo_q[2];
			default: corner = '0;
		endcase
	end

	assign mul_a = (state_q == fbsc_pkg::ST_RAW) ? raw_c : comp;
	assign mul_b = (state_q == fbsc_pkg::ST_RAW) ? raw_c : corner;

	fbsc_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// exact dot against minus the scaled plane offset plus sphere radius
	assign total  = acc_q + 66'(prod);
	assign rhs    = -((66'(comp) + 66'(ext_q)) <<< FRAC_BITS);
	assign reject = total < rhs;

	assign sqrt_start = (state_q == fbsc_pkg::ST_RAW) && (k_q == 2'd3);

	fbsc_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.x      (sum_q + 64'(prod)),
		.stat   (sqrt_stat),
		.root   (root)
	);

	assign mag       = raw_q[k_q][31] ? 32'(-33'(raw_q[k_q])) : 32'(raw_q[k_q]);
	assign div_start = (state_q == fbsc_pkg::ST_NORM) && (len_q != '0);

	fbsc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (64'(mag) << FRAC_BITS),
		.den    (len_q),
		.stat   (div_stat),
		.quot   (quot)
	);

	// saturate the quotient back into the signed format
	always_comb begin
		if (raw_q[k_q][31])
			nrm = (quot > 64'h8000_0000) ? fbsc_pkg::FMT_MIN : 32'(-quot);
		else
			nrm = (quot > 64'h7fff_ffff) ? fbsc_pkg::FMT_MAX : quot[31:0];
	end

	assign norm_adv = ((state_q == fbsc_pkg::ST_NORM) && (len_q == '0)) ||
		((state_q == fbsc_pkg::ST_DIV) && div_stat.done);

	assign fin_status = !ready_q ? fbsc_pkg::STAT_NOPLN :
		(degen_q ? fbsc_pkg::STAT_DEGEN : fbsc_pkg::STAT_OK);

	// storage writes
	always_ff @(posedge clk) begin
		if (accept && mode == fbsc_pkg::MODE_LOAD) begin
			row3_q[column_index]          <= extra_value;
			rowx_q[{2'd0, column_index}]  <= first_x;
			rowx_q[{2'd1, column_index}]  <= first_y;
			rowx_q[{2'd2, column_index}]  <= first_z;
		end
		if (accept) begin
			if (mode == fbsc_pkg::MODE_BOX) begin
				lo_q[0] <= fbsc_pkg::sat32(33'(first_x) + 33'(offset_x));
				lo_q[1] <= fbsc_pkg::sat32(33'(first_y) + 33'(offset_y));
				lo_q[2] <= fbsc_pkg::sat32(33'(first_z) + 33'(offset_z));
				hi_q[0] <= fbsc_pkg::sat32(33'(second_x) + 33'(offset_x));
				hi_q[1] <= fbsc_pkg::sat32(33'(second_y) + 33'(offset_y));
				hi_q[2] <= fbsc_pkg::sat32(33'(second_z) + 33'(offset_z));
				ext_q   <= '0;
			end else begin
				// sphere center serves as both corners
				lo_q[0] <= offset_x;
				lo_q[1] <= offset_y;
				lo_q[2] <= offset_z;
				hi_q[0] <= offset_x;
				hi_q[1] <= offset_y;
				hi_q[2] <= offset_z;
				ext_q   <= 33'(extra_value);
			end
		end
		if (state_q == fbsc_pkg::ST_RAW)
			raw_q[k_q] <= raw_c;
		if (norm_adv)
			pl_q[{p_q, k_q}] <= (len_q == '0) ? '0 : nrm;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fbsc_pkg::ST_IDLE;
			p_q         <= '0;
			k_q         <= '0;
			acc_q       <= '0;
			sum_q       <= '0;
			len_q       <= '0;
			cols_q      <= '0;
			ready_q     <= 1'b0;
			degen_q     <= 1'b0;
			vis_q       <= 1'b0;
			out_valid_q <= 1'b0;
			visible_q   <= 1'b0;
			status_q    <= fbsc_pkg::STAT_OK;
		end else begin
			// the result state refills the output register itself
			if (out_valid_q && out_ready && state_q != fbsc_pkg::ST_FIN)
				out_valid_q <= 1'b0;
			case (state_q)
				fbsc_pkg::ST_IDLE: begin
					p_q   <= '0;
					k_q   <= '0;
					vis_q <= 1'b0;
					if (accept) begin
						state_q <= fbsc_pkg::ST_FIN;
						if (mode == fbsc_pkg::MODE_LOAD) begin
							if (cols_nx == 4'hf) begin
								cols_q  <= '0;
								degen_q <= 1'b0;
								state_q <= fbsc_pkg::ST_RAW;
							end else begin
								cols_q <= cols_nx;
							end
						end else if ((mode == fbsc_pkg::MODE_BOX ||
							mode == fbsc_pkg::MODE_SPHERE) && !not_ready &&
							!(mode == fbsc_pkg::MODE_BOX && sentinel)) begin
							state_q <= fbsc_pkg::ST_TEST;
						end
					end
				end
				fbsc_pkg::ST_RAW: begin
					// squares of x, y, z arrive in the cycle after issue
					case (k_q)
						2'd1:    sum_q <= 64'(prod);
						2'd2:    sum_q <= sum_q + 64'(prod);
						default: sum_q <= sum_q;
					endcase
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3)
						state_q <= fbsc_pkg::ST_SQRT;
				end
				fbsc_pkg::ST_SQRT: begin
					if (sqrt_stat.done) begin
						len_q   <= root;
						k_q     <= '0;
						state_q <= fbsc_pkg::ST_NORM;
					end
				end
				fbsc_pkg::ST_NORM, fbsc_pkg::ST_DIV: begin
					if (div_start)
						state_q <= fbsc_pkg::ST_DIV;
					if (norm_adv) begin
						if (len_q == '0)
							degen_q <= 1'b1;
						state_q <= fbsc_pkg::ST_NORM;
						k_q     <= k_q + 2'd1;
						if (k_q == 2'd3) begin
							if (p_q == 3'(fbsc_pkg::NUM_PLANES - 1)) begin
								ready_q <= 1'b1;
								state_q <= fbsc_pkg::ST_FIN;
							end else begin
								p_q     <= p_q + 3'd1;
								state_q <= fbsc_pkg::ST_RAW;
							end
						end
					end
				end
				fbsc_pkg::ST_TEST: begin
					acc_q <= (k_q == 2'd0) ? '0 : total;
					k_q   <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						if (reject) begin
							vis_q   <= 1'b0;
							state_q <= fbsc_pkg::ST_FIN;
						end else if (p_q == 3'(fbsc_pkg::NUM_PLANES - 1)) begin
							vis_q   <= 1'b1;
							state_q <= fbsc_pkg::ST_FIN;
						end else begin
							p_q <= p_q + 3'd1;
						end
					end
				end
				fbsc_pkg::ST_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						visible_q   <= vis_q && (fin_status == fbsc_pkg::STAT_OK);
						status_q    <= fin_status;
						state_q     <= fbsc_pkg::ST_IDLE;
					end
				end
				default: state_q <= fbsc_pkg::ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign visible   = visible_q;
	assign status    = status_q;

	// a visible result always carries ok status
	a_vis_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(visible && status != fbsc_pkg::STAT_OK))
		else $error("visible with non-ok status");

	// planes once built stay built
	a_ready_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(ready_q))
		else $error("planes_ready dropped");

	// square root only starts from the raw pass and never while either iterative unit is busy
	a_sqrt_start: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_start |-> !sqrt_stat.busy && !div_stat.busy)
		else $error("unit restarted while busy");

	// a test walk only runs on usable planes
	a_test_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fbsc_pkg::ST_TEST) |-> (ready_q && !degen_q))
		else $error("test without usable planes");
endmodule
